### src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define BSM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent on the next edge
`define BSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/bsm_pkg.sv
// shared types and constants of the stack machine
`default_nettype none
package bsm_pkg;
	localparam int DATA_W = 31;
	localparam int LIMIT_W = 30;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd1000000000;

	typedef enum logic [3:0] {
		OP_START  = 4'd0,
		OP_NUM    = 4'd1,
		OP_POP    = 4'd2,
		OP_INV    = 4'd3,
		OP_DUP    = 4'd4,
		OP_SWP    = 4'd5,
		OP_ADD    = 4'd6,
		OP_SUB    = 4'd7,
		OP_MUL    = 4'd8,
		OP_DIV    = 4'd9,
		OP_MOD    = 4'd10,
		OP_FINISH = 4'd11
	} op_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? 32'(-v) : 32'(v);
	endfunction
endpackage
`default_nettype wire

### src/bsm_if.sv
// handshake interfaces for commands and results
`default_nettype none
interface bsm_cmd_if;
	logic valid;
	logic ready;
	logic [3:0] opcode;
	logic signed [30:0] operand;
	modport source (output valid, output opcode, output operand, input ready);
	modport sink (input valid, input opcode, input operand, output ready);
endinterface

interface bsm_rsp_if;
	logic valid;
	logic ready;
	logic signed [30:0] result_value;
	logic error;
	modport source (output valid, output result_value, output error, input ready);
	modport sink (input valid, input result_value, input error, output ready);
endinterface
`default_nettype wire

### src/bsm_stack_ram.sv
// stack memory with one write port and one registered read port
`default_nettype none
module bsm_stack_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic clk,
	input  wire logic wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [bsm_pkg::DATA_W-1:0] wr_data,
	input  wire logic rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [bsm_pkg::DATA_W-1:0] rd_data
);
	logic [bsm_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

### src/bsm_divider.sv
// iterative restoring divider on unsigned magnitudes
`default_nettype none
module bsm_divider #(
	parameter int W = 31
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CNTW = $clog2(W + 1);

	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic [W-1:0] dv_q;
	logic [W:0] sh;
	logic take;

	assign sh = {remainder, quotient[W-1]};
	assign take = sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			remainder <= '0;
			quotient <= dividend;
			dv_q <= divisor;
		end else if (busy_q) begin
			remainder <= take ? W'(sh - {1'b0, dv_q}) : sh[W-1:0];
			quotient <= {quotient[W-2:0], take};
		end
	end
endmodule
`default_nettype wire

### src/bounded_stack_machine.sv
// top level: rpn stack machine with cached top entries and memory-backed stack
// steps: most commands end in S_IDLE; pops with 3+ entries then refill in S_REFILL,
// MUL goes via S_MUL (registered product), DIV and MOD via S_DIV (bit-serial divider),
// and MUL, DIV and MOD also refill in S_REFILL when they pop with 3+ entries
// a command is taken only in S_IDLE; a FINISH result sits in an output register
// reset: stack empty, error clear, limit 1000000000; stack memory is not cleared
`default_nettype none
`include "assert_macros.svh"
module bounded_stack_machine #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bsm_cmd_if.sink cmd,
	bsm_rsp_if.source rsp,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = bsm_pkg::DATA_W;
	localparam int LW = bsm_pkg::LIMIT_W;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_REFILL} state_t;

	state_t state_q, state_d;
	logic signed [DW-1:0] top_q, top_d, next_q, next_d;
	logic [CW-1:0] count_q, count_d;
	logic err_q, err_d;
	logic [LW-1:0] limit_q;
	logic signed [61:0] prod_s1;
	logic opdiv_q, qneg_q, rneg_q;
	logic out_valid_q;
	logic signed [DW-1:0] out_value_q;
	logic out_error_q;

	logic accept;
	bsm_pkg::op_t op;
	logic wr_en, rd_en;
	logic [DW-1:0] rd_data;
	logic div_start, div_done;
	logic [DW-1:0] div_q, div_r, a_mag, b_mag;
	logic signed [31:0] sum, diff;
	logic [61:0] prod_mag;
	logic [DW-1:0] commit_val;
	logic commit;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32 - LW){1'b0}}, limit_q};

	assign cmd.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept = cmd.valid && cmd.ready;
	assign op = bsm_pkg::op_t'(cmd.opcode);
	assign rsp.valid = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.error = out_error_q;

	assign a_mag = top_q[DW-1] ? DW'(-top_q) : DW'(top_q);
	assign b_mag = next_q[DW-1] ? DW'(-next_q) : DW'(next_q);
	assign sum = 32'(next_q) + 32'(top_q);
	assign diff = 32'(next_q) - 32'(top_q);
	assign prod_mag = prod_s1[61] ? 62'(-prod_s1) : 62'(prod_s1);

	bsm_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(AW'(count_q - CW'(2))),
		.wr_data(next_q),
		.rd_en(rd_en),
		.rd_addr(AW'(count_q - CW'(3))),
		.rd_data(rd_data)
	);

	bsm_divider #(.W(DW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(b_mag),
		.divisor(a_mag),
		.done(div_done),
		.quotient(div_q),
		.remainder(div_r)
	);

	always_comb begin
		state_d = state_q;
		top_d = top_q;
		next_d = next_q;
		count_d = count_q;
		err_d = err_q;
		wr_en = 1'b0;
		div_start = 1'b0;
		commit = 1'b0;
		commit_val = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == bsm_pkg::OP_START) begin
						count_d = CW'(1);
						top_d = cmd.operand;
						err_d = 1'b0;
					end else if (!err_q) begin
						case (op)
							bsm_pkg::OP_NUM, bsm_pkg::OP_DUP: begin
								if ((op == bsm_pkg::OP_DUP && count_q == '0) ||
									count_q >= CW'(STACK_DEPTH)) begin
									err_d = 1'b1;
								end else begin
									wr_en = count_q >= CW'(2);
									next_d = top_q;
									top_d = (op == bsm_pkg::OP_NUM) ? cmd.operand : top_q;
									count_d = count_q + CW'(1);
								end
							end
							bsm_pkg::OP_POP: begin
								if (count_q == '0) begin
									err_d = 1'b1;
								end else begin
									commit = 1'b1;
									commit_val = next_q;
								end
							end
							bsm_pkg::OP_INV: begin
								if (count_q == '0) begin
									err_d = 1'b1;
								end else begin
									top_d = DW'(-top_q);
								end
							end
							bsm_pkg::OP_SWP: begin
								if (count_q < CW'(2)) begin
									err_d = 1'b1;
								end else begin
									top_d = next_q;
									next_d = top_q;
								end
							end
							bsm_pkg::OP_ADD, bsm_pkg::OP_SUB: begin
								if (count_q < CW'(2)) begin
									err_d = 1'b1;
								end else if (bsm_pkg::mag32((op == bsm_pkg::OP_ADD) ? sum : diff)
									> {2'b0, limit_q}) begin
									err_d = 1'b1;
								end else begin
									commit = 1'b1;
									commit_val = (op == bsm_pkg::OP_ADD) ? sum[DW-1:0]
										: diff[DW-1:0];
								end
							end
							bsm_pkg::OP_MUL: begin
								if (count_q < CW'(2)) begin
									err_d = 1'b1;
								end else begin
									state_d = S_MUL;
								end
							end
							bsm_pkg::OP_DIV, bsm_pkg::OP_MOD: begin
								if (count_q < CW'(2) || top_q == '0) begin
									err_d = 1'b1;
								end else begin
									div_start = 1'b1;
									state_d = S_DIV;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_MUL: begin
				if (prod_mag > {32'd0, limit_q}) begin
					err_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					commit = 1'b1;
					commit_val = prod_s1[DW-1:0];
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (opdiv_q) begin
						if ({1'b0, div_q} > {2'b0, limit_q}) begin
							err_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							commit = 1'b1;
							commit_val = qneg_q ? DW'(-div_q) : div_q;
						end
					end else begin
						commit = 1'b1;
						commit_val = rneg_q ? DW'(-div_r) : div_r;
					end
				end
			end
			S_REFILL: begin
				next_d = rd_data;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rd_en = commit && (count_q >= CW'(3));
		if (commit) begin
			top_d = commit_val;
			count_d = count_q - CW'(1);
			state_d = rd_en ? S_REFILL : S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q <= 1'b0;
			limit_q <= bsm_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q <= err_d;
			if (psel && penable && pwrite && !paddr[2]) begin
				limit_q <= pwdata[LW-1:0];
			end
			if (accept && op == bsm_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		next_q <= next_d;
		prod_s1 <= 62'(next_q) * 62'(top_q);
		if (div_start) begin
			opdiv_q <= (op == bsm_pkg::OP_DIV);
			qneg_q <= top_q[DW-1] ^ next_q[DW-1];
			rneg_q <= next_q[DW-1];
		end
		if (accept && op == bsm_pkg::OP_FINISH) begin
			out_error_q <= err_q || (count_q != CW'(1));
			out_value_q <= (err_q || (count_q != CW'(1))) ? '0 : top_q;
		end
	end

	`BSM_ASSERT(a_count_bound, count_q <= CW'(STACK_DEPTH))
	`BSM_ASSERT(a_busy_not_ready, (state_q != S_IDLE) |-> !cmd.ready)
	`BSM_ASSERT_NEXT(a_rsp_held, out_valid_q && !rsp.ready, out_valid_q)
	`BSM_ASSERT_NEXT(a_err_sticky, err_q && !(accept && op == bsm_pkg::OP_START), err_q)
endmodule
`default_nettype wire

### tb/bounded_stack_machine_tb.sv
// self-checking testbench for the bounded stack machine: random rpn programs against a predictor
`default_nettype none
module bounded_stack_machine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0] opcode;
		logic signed [30:0] operand;
	} command_t;

	typedef struct {
		logic signed [30:0] value;
		logic error;
	} finish_t;

	localparam int DEPTH = 1024;
	localparam logic [2:0] LIMIT_ADDR = 3'd0;
	localparam logic [3:0] OP_SPARE_LO = 4'd12;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bsm_cmd_if cmd_if ();
	bsm_rsp_if rsp_if ();

	bounded_stack_machine #(.STACK_DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	command_t pending_cmds[$];
	finish_t finish_expected[$];
	command_t cur_cmd;

	logic signed [30:0] shadow_stack[DEPTH];
	int shadow_count = 0;
	bit shadow_error = 0;
	logic [29:0] shadow_limit = bsm_pkg::LIMIT_RESET;

	int fails = 0;
	int cmds_sent = 0;
	int finishes_seen = 0;
	int errors_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit cmd_taken = 0;
	bit hold_rsp = 0;
	bit hold_go = 0;

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.opcode = '0;
		cmd_if.operand = '0;
		rsp_if.ready = 1'b0;
	end

	function automatic bit over_limit(longint r);
		longint m;
		m = (r < 0) ? -r : r;
		return m > longint'(shadow_limit);
	endfunction

	// updates the shadow stack, or queues the expected result of a FINISH, for one accepted command
	task automatic apply_command(command_t c);
		longint a, b, r;
		bit ok;
		logic signed [30:0] t;
		finish_t f;
		ok = 1;
		if (c.opcode == bsm_pkg::OP_FINISH) begin
			f.error = shadow_error || (shadow_count != 1);
			f.value = f.error ? '0 : shadow_stack[0];
			finish_expected = {finish_expected, f};
			return;
		end
		if (c.opcode == bsm_pkg::OP_START) begin
			shadow_count = 1;
			shadow_error = 0;
			shadow_stack[0] = c.operand;
			return;
		end
		if (shadow_error || c.opcode > bsm_pkg::OP_FINISH)
			return;
		case (c.opcode)
			bsm_pkg::OP_NUM: begin
				if (shadow_count >= DEPTH) ok = 0;
				else begin
					shadow_stack[shadow_count] = c.operand;
					shadow_count++;
				end
			end
			bsm_pkg::OP_POP: begin
				if (shadow_count == 0) ok = 0;
				else shadow_count--;
			end
			bsm_pkg::OP_INV: begin
				if (shadow_count == 0) ok = 0;
				else shadow_stack[shadow_count-1] = -shadow_stack[shadow_count-1];
			end
			bsm_pkg::OP_DUP: begin
				if (shadow_count == 0 || shadow_count >= DEPTH) ok = 0;
				else begin
					shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
					shadow_count++;
				end
			end
			bsm_pkg::OP_SWP: begin
				if (shadow_count < 2) ok = 0;
				else begin
					t = shadow_stack[shadow_count-1];
					shadow_stack[shadow_count-1] = shadow_stack[shadow_count-2];
					shadow_stack[shadow_count-2] = t;
				end
			end
			default: begin
				if (shadow_count < 2) ok = 0;
				else begin
					a = shadow_stack[shadow_count-1];
					b = shadow_stack[shadow_count-2];
					r = 0;
					case (c.opcode)
						bsm_pkg::OP_ADD: r = b + a;
						bsm_pkg::OP_SUB: r = b - a;
						bsm_pkg::OP_MUL: r = b * a;
						bsm_pkg::OP_DIV: if (a == 0) ok = 0; else r = b / a;
						default: if (a == 0) ok = 0; else r = b % a;
					endcase
					if (ok && c.opcode != bsm_pkg::OP_MOD && over_limit(r)) ok = 0;
					if (ok) begin
						shadow_count -= 2;
						shadow_stack[shadow_count] = r[30:0];
						shadow_count++;
					end
				end
			end
		endcase
		if (!ok) shadow_error = 1;
	endtask

	// command acceptance and result checking
	always @(posedge clk) begin
		if (cmd_if.valid && cmd_if.ready) begin
			apply_command(cur_cmd);
			cmd_taken = 1;
			cmds_sent++;
		end
		if (rsp_if.valid && rsp_if.ready) begin
			finishes_seen++;
			if (rsp_if.error) errors_seen++;
			if (finish_expected.size() == 0) begin
				$display("%0t: unexpected result value=%0d error=%0b", $time,
					rsp_if.result_value, rsp_if.error);
				fails++;
			end else begin
				finish_t f;
				f = finish_expected.pop_front();
				if (rsp_if.result_value !== f.value || rsp_if.error !== f.error) begin
					$display("%0t: mismatch expected value=%0d error=%0b actual value=%0d error=%0b",
						$time, f.value, f.error, rsp_if.result_value, rsp_if.error);
					fails++;
				end
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		if (!cmd_if.valid || cmd_taken) begin
			cmd_taken = 0;
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_cmd = pending_cmds.pop_front();
				cmd_if.opcode <= cur_cmd.opcode;
				cmd_if.operand <= cur_cmd.operand;
				cmd_if.valid <= 1'b1;
			end else
				cmd_if.valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk)
		rsp_if.ready <= !(hold_rsp || $urandom_range(99) < recv_stall_pct);

	// long receiver hold-off
	initial begin
		wait (hold_go);
		hold_rsp = 1;
		repeat (600) @(posedge clk);
		hold_rsp = 0;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic add_cmd(logic [3:0] op, logic signed [30:0] val);
		command_t c;
		c.opcode = op;
		c.operand = val;
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic logic signed [30:0] rand_operand();
		case ($urandom_range(9))
			0: return 31'sd1073741823;
			1: return -31'sd1073741823;
			2: return 31'h40000000;
			3: return '0;
			4, 5: return 31'($urandom);
			default: return 31'($signed($urandom_range(60)) - 30);
		endcase
	endfunction

	// one well-formed program, sometimes with noise in it
	task automatic add_program(int n);
		int depth;
		logic [3:0] op;
		depth = 1;
		add_cmd(bsm_pkg::OP_START, rand_operand());
		repeat (n) begin
			if ($urandom_range(9) == 0)
				op = 4'($urandom_range(15));
			else if (depth < 2)
				op = ($urandom_range(2) == 0) ? bsm_pkg::OP_DUP : bsm_pkg::OP_NUM;
			else
				op = 4'($urandom_range(bsm_pkg::OP_MOD, bsm_pkg::OP_NUM));
			add_cmd(op, rand_operand());
			case (op)
				bsm_pkg::OP_NUM, bsm_pkg::OP_DUP: depth++;
				bsm_pkg::OP_POP, bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL,
				bsm_pkg::OP_DIV, bsm_pkg::OP_MOD: depth--;
				bsm_pkg::OP_START: depth = 1;
				default: ;
			endcase
		end
		if ($urandom_range(9) < 7)
			for (int i = 1; i < depth; i++)
				add_cmd(4'($urandom_range(bsm_pkg::OP_MOD, bsm_pkg::OP_ADD)), '0);
		add_cmd(bsm_pkg::OP_FINISH, rand_operand());
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || cmd_if.valid || finish_expected.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [29:0] lim);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {2'b0, lim};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[29:0] !== lim) begin
			$display("%0t: limit readback expected %0d actual %0d", $time, lim, prdata[29:0]);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		shadow_limit = lim;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cases
		add_cmd(bsm_pkg::OP_START, 31'sd5); add_cmd(bsm_pkg::OP_NUM, 31'sd7);
		add_cmd(bsm_pkg::OP_ADD, '0); add_cmd(bsm_pkg::OP_FINISH, '0);
		add_cmd(bsm_pkg::OP_START, 31'h40000000); add_cmd(bsm_pkg::OP_INV, '0);
		add_cmd(bsm_pkg::OP_FINISH, '0);
		add_cmd(bsm_pkg::OP_START, -31'sd7); add_cmd(bsm_pkg::OP_NUM, 31'sd2);
		add_cmd(bsm_pkg::OP_DUP, '0); add_cmd(bsm_pkg::OP_SWP, '0);
		add_cmd(bsm_pkg::OP_MOD, '0); add_cmd(bsm_pkg::OP_DIV, '0);
		add_cmd(bsm_pkg::OP_FINISH, '0);
		add_cmd(bsm_pkg::OP_START, 31'sd1); add_cmd(bsm_pkg::OP_POP, '0);
		add_cmd(bsm_pkg::OP_POP, '0);
		add_cmd(bsm_pkg::OP_START, 31'sd1073741823); add_cmd(bsm_pkg::OP_NUM, 31'sd3);
		add_cmd(bsm_pkg::OP_MUL, '0);
		add_cmd(bsm_pkg::OP_NUM, -31'sd1073741823); add_cmd(OP_SPARE_LO, 31'sd1);
		add_cmd(OP_SPARE_HI, '0);
		add_cmd(bsm_pkg::OP_FINISH, '0);
		add_cmd(bsm_pkg::OP_START, -31'sd9); add_cmd(bsm_pkg::OP_NUM, '0);
		add_cmd(bsm_pkg::OP_DIV, '0); add_cmd(bsm_pkg::OP_FINISH, '0);
		drain();

		// zero limit, sender idle
		write_limit('0);
		send_idle_pct = 56;
		repeat (8) add_program($urandom_range(12));
		drain();

		// widest limit, receiver stalls and one long hold-off
		write_limit(30'h3FFFFFFF);
		send_idle_pct = 0;
		recv_stall_pct = 56;
		hold_go = 1;
		repeat (10) add_program($urandom_range(6));
		drain();

		// small limit, both sides idle, full stack
		write_limit(30'd1000);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		add_cmd(bsm_pkg::OP_START, 31'sd11);
		for (int i = 2; i < DEPTH; i++) add_cmd(bsm_pkg::OP_NUM, rand_operand());
		add_cmd(bsm_pkg::OP_DUP, '0);
		add_cmd(bsm_pkg::OP_FINISH, '0);
		add_cmd(bsm_pkg::OP_NUM, '0);
		add_cmd(bsm_pkg::OP_FINISH, '0);
		repeat (8) add_program($urandom_range(10));
		drain();

		// random limit, no idling, sender pauses midway
		write_limit(30'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) add_program($urandom_range(14));
		while (pending_cmds.size() != 0 || cmd_if.valid || finish_expected.size() != 0)
			@(posedge clk);
		repeat (8) add_program($urandom_range(14));
		drain();

		$display("ran %0d commands over five limit settings and four idling mixes", cmds_sent);
		$display("checked %0d finish results, %0d of them errors", finishes_seen, errors_seen);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

### bounded_stack_machine.f
+incdir+src
src/bsm_pkg.sv
src/bsm_if.sv
src/bsm_stack_ram.sv
src/bsm_divider.sv
src/bounded_stack_machine.sv
tb/bounded_stack_machine_tb.sv
